@@ hdl/tti_pkg.sv @@
// shared types, constants and resistance table for the thermistor interpolation core
package tti_pkg;

  // default sizes
  localparam int ADC_BITS_DEF     = 10;
  localparam int TABLE_POINTS_DEF = 37;

  // fixed field widths
  localparam int SERIES_W  = 20;
  localparam int RES_W     = 19;
  localparam int TEMP_W    = 10;
  localparam int STEP_W    = 6;
  localparam int TBL_IDX_W = 6;

  localparam logic [SERIES_W-1:0] SERIES_RESET = 20'd2200;

  // temperature axis of the table
  localparam int TEMP_FIRST    = -40;
  localparam int TEMP_STEP     = 5;
  localparam int TEMP_ABS_ZERO = -273;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ZERO  = 2'd2
  } status_e;

  // request to the shared divider
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  // thermistor resistance in tenths of an ohm, -40 C upwards in 5 C steps
  function automatic logic [RES_W-1:0] res_entry(input logic [TBL_IDX_W-1:0] idx);
    logic [RES_W-1:0] r;
    case (idx)
      6'd0:    r = 19'd448640;
      6'd1:    r = 19'd336760;
      6'd2:    r = 19'd255240;
      6'd3:    r = 19'd195250;
      6'd4:    r = 19'd150670;
      6'd5:    r = 19'd117240;
      6'd6:    r = 19'd91950;
      6'd7:    r = 19'd72660;
      6'd8:    r = 19'd57840;
      6'd9:    r = 19'd46360;
      6'd10:   r = 19'd37400;
      6'd11:   r = 19'd30370;
      6'd12:   r = 19'd24800;
      6'd13:   r = 19'd20380;
      6'd14:   r = 19'd16830;
      6'd15:   r = 19'd13980;
      6'd16:   r = 19'd11670;
      6'd17:   r = 19'd9789;
      6'd18:   r = 19'd8250;
      6'd19:   r = 19'd6985;
      6'd20:   r = 19'd5940;
      6'd21:   r = 19'd5072;
      6'd22:   r = 19'd4349;
      6'd23:   r = 19'd3743;
      6'd24:   r = 19'd3234;
      6'd25:   r = 19'd2804;
      6'd26:   r = 19'd2440;
      6'd27:   r = 19'd2130;
      6'd28:   r = 19'd1866;
      6'd29:   r = 19'd1640;
      6'd30:   r = 19'd1445;
      6'd31:   r = 19'd1278;
      6'd32:   r = 19'd1133;
      6'd33:   r = 19'd1007;
      6'd34:   r = 19'd898;
      6'd35:   r = 19'd802;
      6'd36:   r = 19'd719;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/tti_ram.sv @@
// generic single-port-write ram with registered read
module tti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tti_div.sv @@
// restoring divider, one quotient bit per cycle, preloadable remainder
module tti_div import tti_pkg::*; #(
  parameter int NUM_W = 34,
  parameter int DIV_W = 19
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [NUM_W-1:0] dvd_i,
  input  logic [DIV_W-1:0] dvs_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DIV_W-1:0] rem_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  dvd_q, dvd_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [DIV_W:0]    rem_sh;
  logic              fits;

  // one compare and subtract step
  assign rem_sh = {rem_q, dvd_q[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = rem_i;
      dvd_d  = dvd_i;
      dvs_d  = dvs_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[NUM_W-2:0], fits};
      if (fits) begin
        rem_d = DIV_W'(rem_sh - {1'b0, dvs_q});
      end else begin
        rem_d = rem_sh[DIV_W-1:0];
      end
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/thermistor_table_interpolation_core.sv @@
// top level: thermistor resistance from adc code, table scan and linear interpolation
//
//  channel   signals                               transaction taken when
//  -------   -----------------------------------   ---------------------------
//  command   start, busy, adc_code_i               start high, busy low
//  result    done_o, temperature_c_o, status_o     done_o high (one cycle)
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i  cfg_valid_i and cfg_ready_o
//
// a zero or full-scale code gives its result in the next cycle; any other code keeps
// busy high through the multiply, the SERIES_W + ADC_BITS + 4 step divide on the shared
// divider, a scan of the one-read-per-cycle table memory and the interpolation divide;
// done_o rises in the same cycle that busy falls
// after reset busy stays high while the table memory is filled
// config writes are taken at any time; results show for one cycle, the receiver cannot stall
module thermistor_table_interpolation_core import tti_pkg::*; #(
  parameter int ADC_BITS     = ADC_BITS_DEF,
  parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [ADC_BITS-1:0]      adc_code_i,
  output logic                     done_o,
  output logic signed [TEMP_W-1:0] temperature_c_o,
  output logic [1:0]               status_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [SERIES_W-1:0]      cfg_data_i
);

  localparam int PROD_W = SERIES_W + ADC_BITS;
  localparam int NUM_W  = PROD_W + 4;
  localparam int DIV_W  = (ADC_BITS > RES_W) ? ADC_BITS : RES_W;
  localparam int AW     = $clog2(TABLE_POINTS);
  localparam int IW     = $clog2(TABLE_POINTS + 1);

  typedef enum logic [8:0] {
    S_FILL  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_DIV1L = 9'b000001000,
    S_DIV1  = 9'b000010000,
    S_HEAD  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_INTP  = 9'b010000000,
    S_DIV2  = 9'b100000000
  } state_e;

  state_e                   state_q, state_d;
  logic [SERIES_W-1:0]      series_q;
  logic [AW-1:0]            fill_q, fill_d;
  logic [IW-1:0]            idx_q, idx_d;
  logic                     first_q, first_d;
  logic [ADC_BITS-1:0]      code_q, code_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [NUM_W-1:0]         r10_q, r10_d;
  logic [RES_W-1:0]         hi_q, hi_d;
  logic [RES_W-1:0]         d_q, d_d;
  logic [RES_W-1:0]         span_q, span_d;
  logic [AW-1:0]            seg_q, seg_d;
  logic [TEMP_W-1:0]        t1_q, t1_d;
  logic                     done_q, done_d;
  logic [TEMP_W-1:0]        temp_q, temp_d;
  status_e                  status_q, status_d;

  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [RES_W-1:0]         ram_rdata;
  div_req_t                 div_req;
  logic [DIV_W-1:0]         div_rem_in;
  logic [NUM_W-1:0]         div_dvd_in;
  logic [DIV_W-1:0]         div_dvs_in;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;
  logic [DIV_W-1:0]         div_rem;
  logic [RES_W+2:0]         five_d;
  logic                     hit;
  logic [TEMP_W-1:0]        sum;
  logic [ADC_BITS-1:0]      full_code;

  assign full_code = {ADC_BITS{1'b1}};

  // resistance table memory
  tti_ram #(
    .WIDTH (RES_W),
    .DEPTH (TABLE_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q),
    .wdata_i (res_entry(TBL_IDX_W'(fill_q))),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared divider for resistance and interpolation fraction
  tti_div #(
    .NUM_W (NUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rem_i  (div_rem_in),
    .dvd_i  (div_dvd_in),
    .dvs_i  (div_dvs_in),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // table read address, held in range after the last entry
  assign ram_raddr = (idx_q < IW'(TABLE_POINTS)) ? idx_q[AW-1:0] : '0;
  assign ram_we    = (state_q == S_FILL);

  // bracket test of the current segment: hi_q is the upper end, ram data the lower
  assign hit = (r10_q <= NUM_W'(hi_q)) && (r10_q >= NUM_W'(ram_rdata)) &&
               (hi_q > ram_rdata);

  // five times the distance into the segment
  assign five_d = {d_q, 2'b00} + (RES_W+3)'(d_q);

  // whole part of the interpolated temperature
  assign sum = t1_q + TEMP_W'(div_quo[2:0]);

  // divider operands
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEP_W'(NUM_W);
    div_rem_in    = '0;
    div_dvd_in    = NUM_W'({prod_q, 3'b000}) + NUM_W'({prod_q, 1'b0});
    div_dvs_in    = DIV_W'(full_code - code_q);
    if (state_q == S_DIV1L) begin
      div_req.start = 1'b1;
    end else if (state_q == S_INTP) begin
      div_req.start = 1'b1;
      div_req.steps = STEP_W'(3);
      div_rem_in    = DIV_W'(five_d >> 3);
      div_dvd_in    = {five_d[2:0], {(NUM_W-3){1'b0}}};
      div_dvs_in    = DIV_W'(span_q);
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    first_d  = first_q;
    code_d   = code_q;
    prod_d   = prod_q;
    r10_d    = r10_q;
    hi_d     = hi_q;
    d_d      = d_q;
    span_d   = span_q;
    seg_d    = seg_q;
    t1_d     = t1_q;
    done_d   = 1'b0;
    temp_d   = temp_q;
    status_d = status_q;
    case (state_q)
      S_FILL: begin
        fill_d = fill_q + AW'(1);
        if (fill_q == AW'(TABLE_POINTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          code_d = adc_code_i;
          if (adc_code_i == '0) begin
            done_d   = 1'b1;
            temp_d   = TEMP_W'(TEMP_ABS_ZERO);
            status_d = ST_ZERO;
          end else if (adc_code_i == full_code) begin
            done_d   = 1'b1;
            temp_d   = '0;
            status_d = ST_RANGE;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(series_q) * PROD_W'(code_q);
        state_d = S_DIV1L;
      end
      S_DIV1L: begin
        state_d = S_DIV1;
      end
      S_DIV1: begin
        idx_d = '0;
        if (div_done) begin
          r10_d   = div_quo;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        idx_d   = IW'(1);
        first_d = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (first_q) begin
          hi_d    = ram_rdata;
          first_d = 1'b0;
          idx_d   = idx_q + IW'(1);
        end else if (hit) begin
          d_d     = hi_q - r10_q[RES_W-1:0];
          span_d  = hi_q - ram_rdata;
          seg_d   = AW'(idx_q - IW'(2));
          state_d = S_INTP;
        end else if (idx_q == IW'(TABLE_POINTS)) begin
          done_d   = 1'b1;
          temp_d   = '0;
          status_d = ST_RANGE;
          state_d  = S_IDLE;
        end else begin
          hi_d  = ram_rdata;
          idx_d = idx_q + IW'(1);
        end
      end
      S_INTP: begin
        t1_d    = TEMP_W'(TEMP_FIRST) + TEMP_W'(seg_q * TEMP_STEP);
        state_d = S_DIV2;
      end
      S_DIV2: begin
        if (div_done) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          // truncate toward zero: negative values with a fraction round up
          if (sum[TEMP_W-1] && (div_rem != '0)) begin
            temp_d = sum + TEMP_W'(1);
          end else begin
            temp_d = sum;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_FILL;
      fill_q   <= '0;
      idx_q    <= '0;
      first_q  <= 1'b0;
      done_q   <= 1'b0;
      series_q <= SERIES_RESET;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      first_q <= first_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        series_q <= cfg_data_i;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    prod_q   <= prod_d;
    r10_q    <= r10_d;
    hi_q     <= hi_d;
    d_q      <= d_d;
    span_q   <= span_d;
    seg_q    <= seg_d;
    t1_q     <= t1_d;
    temp_q   <= temp_d;
    status_q <= status_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign temperature_c_o = temp_q;
  assign status_o        = status_q;

`ifndef ASSERT_OFF
  // an accepted command either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither busy nor answered");

  // a result is only shown once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // divider finishes only while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider finished outside a divide state");

  // out-of-table results carry a zero temperature
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_RANGE) |-> (temperature_c_o == '0))
    else $error("range status with non-zero temperature");
`endif

endmodule
